@@ hdl/fisd_pkg.sv @@
// Shared types, constants and decode functions for the framed image stream deframer.
// No dependencies; every other file in hdl/ imports this package.
package fisd_pkg;

	// Frame buffer size in bytes; payload bytes at or past this count are not stored
	localparam int unsigned BUFFER_BYTES = 65536;

	localparam int unsigned HDR_LEN    = 19;
	localparam int unsigned PREFIX_LEN = 11;
	localparam int unsigned CMD_START  = 15;

	localparam int HDR_CNT_W = 5;

	// Result event kinds
	localparam logic [2:0] EV_NONE       = 3'd0;
	localparam logic [2:0] EV_HDR_OK     = 3'd1;
	localparam logic [2:0] EV_BAD_PREFIX = 3'd2;
	localparam logic [2:0] EV_IMAGE_DONE = 3'd3;
	localparam logic [2:0] EV_DISCONNECT = 3'd4;

	// Input operations
	localparam logic OP_BYTE  = 1'b0;
	localparam logic OP_CLOSE = 1'b1;

	// Command codes
	localparam logic [3:0] CODE_UNKNOWN = 4'd0;
	localparam logic [3:0] CODE_RST     = 4'd1;
	localparam logic [3:0] CODE_USB     = 4'd2;
	localparam logic [3:0] CODE_CLS     = 4'd3;
	localparam logic [3:0] CODE_STOR    = 4'd4;
	localparam logic [3:0] CODE_SYNC    = 4'd5;
	localparam logic [3:0] CODE_IPV4    = 4'd6;
	localparam logic [3:0] CODE_IPV6    = 4'd7;
	localparam logic [3:0] CODE_DATA    = 4'd8;
	localparam logic [3:0] CODE_DATW    = 4'd9;
	localparam logic [3:0] CODE_ZDAT    = 4'd10;
	localparam logic [3:0] CODE_ZDTW    = 4'd11;
	localparam logic [3:0] CODE_GET     = 4'd12;
	localparam logic [3:0] CODE_SET     = 4'd13;
	localparam logic [3:0] CODE_DEL     = 4'd14;

	typedef struct packed {
		logic       operation;
		logic [7:0] data_byte;
	} fisd_item_t;

	typedef struct packed {
		logic        refresh_display;
		logic [31:0] frame_length;
		logic [3:0]  command_code;
		logic [2:0]  event_res;
		logic [7:0]  store_data;
		logic [15:0] store_address;
		logic        store_enable;
	} fisd_result_t;

	// Expected header prefix, one byte per position
	function automatic logic [7:0] prefix_byte(input logic [HDR_CNT_W-1:0] pos);
		logic [7:0] b;
		case (pos)
			5'd0:    b = 8'h4D;
			5'd1:    b = 8'h75;
			5'd2:    b = 8'h6C;
			5'd3:    b = 8'h74;
			5'd4:    b = 8'h69;
			5'd5:    b = 8'h76;
			5'd6:    b = 8'h65;
			5'd7:    b = 8'h72;
			5'd8:    b = 8'h73;
			5'd9:    b = 8'h65;
			5'd10:   b = 8'h3A;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// Four command characters, first received in the top byte
	function automatic logic [3:0] code_of(input logic [31:0] chars);
		logic [3:0] c;
		case (chars)
			"_rst":  c = CODE_RST;
			"_usb":  c = CODE_USB;
			"_cls":  c = CODE_CLS;
			"stor":  c = CODE_STOR;
			"sync":  c = CODE_SYNC;
			"ipv4":  c = CODE_IPV4;
			"ipv6":  c = CODE_IPV6;
			"data":  c = CODE_DATA;
			"datw":  c = CODE_DATW;
			"zdat":  c = CODE_ZDAT;
			"zdtw":  c = CODE_ZDTW;
			"get:":  c = CODE_GET;
			"set:":  c = CODE_SET;
			"del:":  c = CODE_DEL;
			default: c = CODE_UNKNOWN;
		endcase
		return c;
	endfunction

endpackage

@@ hdl/fisd_in_stage.sv @@
// Input register of the deframer: holds one accepted item until the core takes it.
// Depends on fisd_pkg.
module fisd_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  fisd_pkg::fisd_item_t in_item,
	input  logic                take,
	output logic                valid_s1,
	output fisd_pkg::fisd_item_t item_s1
);
	import fisd_pkg::*;

	// Refill in the same cycle as the held item moves on
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

@@ hdl/fisd_core.sv @@
// Deframer state and per-byte decode: header collection, command lookup, payload count.
// Depends on fisd_pkg; state advances only when the held item is taken.
module fisd_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  fisd_pkg::fisd_item_t  item,
	output fisd_pkg::fisd_result_t result
);
	import fisd_pkg::*;

	logic                 in_payload_q;
	logic [HDR_CNT_W-1:0] header_count_q;
	logic                 prefix_good_q;
	logic [31:0]          length_held_q;
	logic [31:0]          command_chars_q;
	logic [31:0]          payload_count_q;
	logic                 refresh_on_end_q;

	logic                 in_payload_d;
	logic [HDR_CNT_W-1:0] header_count_d;
	logic                 prefix_good_d;
	logic [31:0]          length_held_d;
	logic [31:0]          command_chars_d;
	logic [31:0]          payload_count_d;
	logic                 refresh_on_end_d;

	logic [31:0]          count_inc;
	logic [3:0]           code;

	assign count_inc = payload_count_q + 32'd1;
	// in the header the last command character arrives with this byte
	assign code      = code_of(in_payload_q ? command_chars_q
		: {command_chars_q[23:0], item.data_byte});

	always_comb begin
		in_payload_d     = in_payload_q;
		header_count_d   = header_count_q;
		prefix_good_d    = prefix_good_q;
		length_held_d    = length_held_q;
		command_chars_d  = command_chars_q;
		payload_count_d  = payload_count_q;
		refresh_on_end_d = refresh_on_end_q;
		result           = '0;

		if (item.operation == OP_CLOSE) begin
			in_payload_d     = 1'b0;
			header_count_d   = '0;
			prefix_good_d    = 1'b1;
			length_held_d    = '0;
			command_chars_d  = '0;
			payload_count_d  = '0;
			refresh_on_end_d = 1'b0;
			result.event_res = EV_DISCONNECT;
		end else if (in_payload_q) begin
			if (payload_count_q < 32'(BUFFER_BYTES)) begin
				result.store_enable  = 1'b1;
				result.store_address = payload_count_q[15:0];
				result.store_data    = item.data_byte;
			end
			payload_count_d = count_inc;
			if (count_inc >= length_held_q) begin
				result.event_res       = EV_IMAGE_DONE;
				result.command_code    = code;
				result.frame_length    = length_held_q;
				result.refresh_display = refresh_on_end_q;
				in_payload_d           = 1'b0;
				refresh_on_end_d       = 1'b0;
				header_count_d         = '0;
				prefix_good_d          = 1'b1;
			end
		end else begin
			if (header_count_q < HDR_CNT_W'(PREFIX_LEN)) begin
				if (item.data_byte != prefix_byte(header_count_q))
					prefix_good_d = 1'b0;
			end else if (header_count_q < HDR_CNT_W'(CMD_START)) begin
				length_held_d = {length_held_q[23:0], item.data_byte};
			end else begin
				command_chars_d = {command_chars_q[23:0], item.data_byte};
			end

			if (header_count_q == HDR_CNT_W'(HDR_LEN - 1)) begin
				if (!prefix_good_d) begin
					result.event_res = EV_BAD_PREFIX;
				end else begin
					result.event_res       = EV_HDR_OK;
					result.command_code    = code;
					result.frame_length    = length_held_d;
					result.refresh_display = (code == CODE_SYNC);
					if (code == CODE_DATA || code == CODE_DATW) begin
						payload_count_d = '0;
						// a zero-length image has no payload; its refresh is given with the header result
						if (length_held_d == '0) begin
							result.refresh_display = (code == CODE_DATA);
						end else begin
							in_payload_d     = 1'b1;
							refresh_on_end_d = (code == CODE_DATA);
						end
					end
				end
				header_count_d = '0;
				prefix_good_d  = 1'b1;
			end else begin
				header_count_d = header_count_q + HDR_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q     <= 1'b0;
			header_count_q   <= '0;
			prefix_good_q    <= 1'b1;
			length_held_q    <= '0;
			command_chars_q  <= '0;
			payload_count_q  <= '0;
			refresh_on_end_q <= 1'b0;
		end else if (take) begin
			in_payload_q     <= in_payload_d;
			header_count_q   <= header_count_d;
			prefix_good_q    <= prefix_good_d;
			length_held_q    <= length_held_d;
			command_chars_q  <= command_chars_d;
			payload_count_q  <= payload_count_d;
			refresh_on_end_q <= refresh_on_end_d;
		end
	end

endmodule

@@ hdl/fisd_out_stage.sv @@
// Result register of the deframer, holding one result until the receiver takes it.
// Depends on fisd_pkg.
module fisd_out_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  fisd_pkg::fisd_result_t result,
	output logic                  room,
	output logic                  out_valid,
	input  logic                  out_ready,
	output fisd_pkg::fisd_result_t result_q
);
	import fisd_pkg::*;

	// Free when empty or when the held result is transferred this cycle
	assign room = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

endmodule

@@ hdl/framed_image_stream_deframer_top.sv @@
// Top level of the framed image stream deframer.
// Depends on fisd_pkg, fisd_in_stage, fisd_core and fisd_out_stage.
//
// Usage:
//   Slave channel s_axis_*: one transfer per received byte (tuser = 0) or per
//   connection close (tuser = 1, tdata ignored). Master channel m_axis_*: exactly
//   one result transfer per input transfer, in order. The result's tuser carries
//   the event (none, header accepted, bad prefix, image complete, disconnected);
//   tdata carries the frame buffer write and the header details.
//   The result passes through one input register and one result register, with the
//   header/payload decode between them. Throughput is one item per cycle while the
//   receiver takes each result; the decode and its state update lie between the two
//   registers, so an item can follow in the next cycle.
//   When the receiver stalls, the result register holds its transfer and the input
//   register holds one more item; s_axis_tready drops once both are full and rises
//   in the cycle the receiver takes the result.
//   Reset (arst_n low) empties both registers and returns the deframer to header
//   collection with all counts cleared; a close transfer does the same in-band.
module framed_image_stream_deframer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // [0] operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] store_enable, [16:1] store_address, [24:17] store_data,
	// [28:25] command_code, [60:29] frame_length, [61] refresh_display, [63:62] zero
	output logic [63:0] m_axis_tdata,
	output logic [2:0]  m_axis_tuser   // [2:0] event_res
);
	import fisd_pkg::*;

	fisd_item_t   in_item;
	fisd_item_t   item_s1;
	logic         valid_s1;
	logic         room;
	logic         take;
	fisd_result_t result;
	fisd_result_t result_q;

	assign in_item.operation = s_axis_tuser;
	assign in_item.data_byte = s_axis_tdata;

	assign take = valid_s1 && room;

	fisd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	fisd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (item_s1),
		.result (result)
	);

	fisd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.result    (result),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.result_q  (result_q)
	);

	assign m_axis_tdata = {2'b00, result_q.refresh_display, result_q.frame_length,
		result_q.command_code, result_q.store_data, result_q.store_address,
		result_q.store_enable};
	assign m_axis_tuser = result_q.event_res;

endmodule
